### rtl/bipartite_byte_ring_buffer_defines.svh
// assertion macros for the bip buffer checker
`ifndef BIPARTITE_BYTE_RING_BUFFER_DEFINES_SVH
`define BIPARTITE_BYTE_RING_BUFFER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BBRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BBRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bbrb_pkg.sv
// shared constants, codes and types of the bip buffer
package bbrb_pkg;

  localparam int DEPTH_DEF        = 4096;
  localparam int MAX_TRANSFER_DEF = 64;

  localparam int OP_W     = 3;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int HELD_W   = 13;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_WR_START = 3'd0,
    OP_WR_NEXT  = 3'd1,
    OP_READ     = 3'd2,
    OP_PEEK     = 3'd3,
    OP_REMOVE   = 3'd4
  } op_e;

  typedef struct packed {
    logic              status;
    logic              has_data;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [HELD_W-1:0] held_bytes;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } qstat_t;

endpackage

### rtl/bbrb_ram.sv
// byte store: one write port, one read port, registered read data
module bbrb_ram #(
  parameter int DEPTH = bbrb_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bbrb_pkg::BYTE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bbrb_pkg::BYTE_W-1:0] rdata_o
);

  logic [bbrb_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bbrb_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bbrb_outq.sv
// two-entry result queue driving the master stream side
module bbrb_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bbrb_pkg::res_t                res_i,
  output bbrb_pkg::qstat_t              qstat_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [bbrb_pkg::M_DATA_W-1:0] m_tdata_o,
  output logic                          m_tuser_o,
  output logic                          m_tlast_o
);

  bbrb_pkg::res_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;
  bbrb_pkg::res_t head;

  assign pop  = m_tvalid_o & m_tready_i;
  assign head = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

  assign qstat_o.cnt = cnt_q;
  assign qstat_o.pop = pop;

  assign m_tvalid_o = (cnt_q != 2'd0);
  assign m_tdata_o  = {2'b00, head.held_bytes, head.out_byte, head.status};
  assign m_tuser_o  = head.has_data;
  assign m_tlast_o  = head.last;

endmodule

### rtl/bbrb_ctrl.sv
// region bookkeeping, byte streaming and region b relocation around the byte store
module bbrb_ctrl #(
  parameter int DEPTH        = bbrb_pkg::DEPTH_DEF,
  parameter int MAX_TRANSFER = bbrb_pkg::MAX_TRANSFER_DEF,
  localparam int AW          = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [bbrb_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic [bbrb_pkg::OP_W-1:0]     s_tuser_i,
  input  bbrb_pkg::qstat_t              qstat_i,
  output logic                          push_o,
  output bbrb_pkg::res_t                res_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [bbrb_pkg::BYTE_W-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [bbrb_pkg::BYTE_W-1:0]   ram_rdata_i
);

  localparam int SW = AW + 1;
  localparam int CW = ((SW > bbrb_pkg::LEN_W) ? SW : bbrb_pkg::LEN_W) + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] MaxC   = CW'(MAX_TRANSFER);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_RELOC = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [AW-1:0]                a_start_q, a_start_d;
  logic [SW-1:0]                a_size_q, a_size_d;
  logic                         b_active_q, b_active_d;
  logic [SW-1:0]                b_size_q, b_size_d;
  logic [bbrb_pkg::LEN_W-1:0]   wr_left_q, wr_left_d;
  logic                         wr_into_b_q, wr_into_b_d;
  logic                         wr_acc_q, wr_acc_d;
  logic [bbrb_pkg::LEN_W-1:0]   rd_len_q, rd_len_d;
  logic [bbrb_pkg::LEN_W-1:0]   rd_idx_q, rd_idx_d;
  logic [AW-1:0]                rd_base_q, rd_base_d;
  logic [SW-1:0]                rd_asz_q, rd_asz_d;
  logic                         rd_pend_q, rd_pend_d;
  logic                         rd_last_q, rd_last_d;
  logic [bbrb_pkg::HELD_W-1:0]  held_res_q, held_res_d;
  logic                         reloc_q, reloc_d;
  logic [AW-1:0]                mv_src_q, mv_src_d;
  logic [SW-1:0]                mv_len_q, mv_len_d;
  logic [AW-1:0]                mv_cnt_q, mv_cnt_d;
  logic                         mv_vld_q, mv_vld_d;
  logic [AW-1:0]                mv_wa_q, mv_wa_d;

  logic                         acc;
  logic [bbrb_pkg::OP_W-1:0]    s_op;
  logic [CW-1:0]                len_c;
  logic [bbrb_pkg::BYTE_W-1:0]  s_byte;
  logic [CW-1:0]                ast_c, asz_c, bsz_c, held_c, tail_c, aend_c;

  logic                         ws_open, ws_into_b, ws_ok;
  logic                         ap_into_b, ap_b_act, ap_ok;
  logic [CW-1:0]                ap_bsz;
  logic [AW-1:0]                ap_addr;

  logic [CW-1:0]                cn_n, cn_ta, cn_rest, cn_tb, cn_asz0, cn_bsz0;
  logic [CW-1:0]                cn_ast, cn_asz, cn_bsz, cn_held;
  logic                         cn_bact, cn_reloc;

  logic [CW-1:0]                rd_idx_c, rd_asz_c, rd_addr_c;
  logic                         rd_is_last, room, mv_is_last;

  assign acc    = s_tvalid_i & s_tready_o;
  assign s_op   = s_tuser_i;
  assign len_c  = CW'(s_tdata_i[bbrb_pkg::LEN_W-1:0]);
  assign s_byte = s_tdata_i[bbrb_pkg::LEN_W +: bbrb_pkg::BYTE_W];

  assign ast_c  = CW'(a_start_q);
  assign asz_c  = CW'(a_size_q);
  assign bsz_c  = CW'(b_size_q);
  assign held_c = asz_c + bsz_c;
  assign aend_c = ast_c + asz_c;
  assign tail_c = DepthC - aend_c;

  // a new write opens region b when the tail after a is the smaller space
  assign ws_open   = !b_active_q && (tail_c < ast_c);
  assign ws_into_b = b_active_q || ws_open;
  assign ws_ok     = b_active_q ? ((ast_c >= bsz_c) && ((ast_c - bsz_c) >= len_c)) :
                     ws_open    ? (ast_c >= len_c) : (tail_c >= len_c);

  // append target: placement of this write start, or that of the pending write
  assign ap_into_b = (s_op == bbrb_pkg::OP_WR_START) ? ws_into_b : wr_into_b_q;
  assign ap_b_act  = (s_op == bbrb_pkg::OP_WR_START) ? ws_into_b : b_active_q;
  assign ap_bsz    = ((s_op == bbrb_pkg::OP_WR_START) && ws_open) ? '0 : bsz_c;
  assign ap_ok     = ap_into_b ? (ap_b_act && (ap_bsz < ast_c) && (ap_bsz < DepthC)) :
                                 (aend_c < DepthC);
  assign ap_addr   = ap_into_b ? ap_bsz[AW-1:0] : aend_c[AW-1:0];

  // consume: a first, then the front of b; a emptied hands b over as the new a
  assign cn_n    = (s_op == bbrb_pkg::OP_REMOVE && len_c > held_c) ? held_c : len_c;
  assign cn_ta   = (cn_n < asz_c) ? cn_n : asz_c;
  assign cn_rest = cn_n - cn_ta;
  assign cn_tb   = (cn_rest < bsz_c) ? cn_rest : bsz_c;
  assign cn_asz0 = asz_c - cn_ta;
  assign cn_bsz0 = bsz_c - cn_tb;

  always_comb begin
    cn_ast   = ast_c + cn_ta;
    cn_asz   = cn_asz0;
    cn_bact  = b_active_q;
    cn_bsz   = cn_bsz0;
    cn_reloc = 1'b0;
    if (cn_asz0 == '0) begin
      cn_ast  = '0;
      cn_bact = 1'b0;
      cn_bsz  = '0;
      if (b_active_q && (cn_bsz0 != '0)) begin
        cn_asz   = cn_bsz0;
        cn_reloc = (cn_tb != '0) && ((cn_tb + cn_bsz0) <= DepthC);
      end else begin
        cn_asz = '0;
      end
    end
  end

  assign cn_held = cn_asz + cn_bsz;

  // byte streaming address: a's bytes from its start, then b's from offset zero
  assign rd_idx_c   = CW'(rd_idx_q);
  assign rd_asz_c   = CW'(rd_asz_q);
  assign rd_addr_c  = (rd_idx_c < rd_asz_c) ? (CW'(rd_base_q) + rd_idx_c) :
                                              (rd_idx_c - rd_asz_c);
  assign rd_is_last = (rd_idx_q == (rd_len_q - bbrb_pkg::LEN_W'(1)));
  assign mv_is_last = (SW'(mv_cnt_q) == (mv_len_q - SW'(1)));

  // a read issued now lands in the queue next cycle
  assign room = ({1'b0, qstat_i.cnt} + {2'b00, rd_pend_q}) < (3'd2 + {2'b00, qstat_i.pop});

  assign s_tready_o = (state_q == ST_IDLE) && !rd_pend_q && !mv_vld_q && (qstat_i.cnt != 2'd2);

  always_comb begin
    state_d     = state_q;
    a_start_d   = a_start_q;
    a_size_d    = a_size_q;
    b_active_d  = b_active_q;
    b_size_d    = b_size_q;
    wr_left_d   = wr_left_q;
    wr_into_b_d = wr_into_b_q;
    wr_acc_d    = wr_acc_q;
    rd_len_d    = rd_len_q;
    rd_idx_d    = rd_idx_q;
    rd_base_d   = rd_base_q;
    rd_asz_d    = rd_asz_q;
    rd_pend_d   = 1'b0;
    rd_last_d   = rd_last_q;
    held_res_d  = held_res_q;
    reloc_d     = reloc_q;
    mv_src_d    = mv_src_q;
    mv_len_d    = mv_len_q;
    mv_cnt_d    = mv_cnt_q;
    mv_vld_d    = 1'b0;
    mv_wa_d     = mv_cnt_q;

    push_o              = 1'b0;
    res_o               = '0;
    res_o.last          = 1'b1;
    res_o.held_bytes    = bbrb_pkg::HELD_W'(held_c);
    ram_we_o            = 1'b0;
    ram_waddr_o         = ap_addr;
    ram_wdata_o         = s_byte;
    ram_re_o            = 1'b0;
    ram_raddr_o         = rd_addr_c[AW-1:0];

    unique case (state_q)
      ST_IDLE: if (acc) begin
        push_o = 1'b1;
        unique case (s_op)
          bbrb_pkg::OP_WR_START: begin
            wr_left_d   = '0;
            wr_acc_d    = 1'b0;
            wr_into_b_d = 1'b0;
            if (len_c > MaxC) begin
              res_o.status = 1'b1;
            end else begin
              wr_into_b_d = ws_into_b;
              wr_acc_d    = ws_ok;
              res_o.status = !ws_ok;
              if (ws_open) begin
                b_active_d = 1'b1;
                b_size_d   = '0;
              end
              if (len_c != '0) begin
                wr_left_d = s_tdata_i[bbrb_pkg::LEN_W-1:0] - bbrb_pkg::LEN_W'(1);
                if (ws_ok && ap_ok) begin
                  ram_we_o = 1'b1;
                  res_o.held_bytes = bbrb_pkg::HELD_W'(held_c + CW'(1));
                  if (ap_into_b) begin
                    b_size_d = SW'(ap_bsz + CW'(1));
                  end else begin
                    a_size_d = SW'(asz_c + CW'(1));
                  end
                end else begin
                  res_o.status = 1'b1;
                end
              end
            end
          end
          bbrb_pkg::OP_WR_NEXT: begin
            res_o.status = 1'b1;
            if (wr_left_q != '0) begin
              wr_left_d = wr_left_q - bbrb_pkg::LEN_W'(1);
              if (wr_acc_q && ap_ok) begin
                ram_we_o     = 1'b1;
                res_o.status = 1'b0;
                res_o.held_bytes = bbrb_pkg::HELD_W'(held_c + CW'(1));
                if (ap_into_b) begin
                  b_size_d = SW'(ap_bsz + CW'(1));
                end else begin
                  a_size_d = SW'(asz_c + CW'(1));
                end
              end
            end
          end
          bbrb_pkg::OP_READ, bbrb_pkg::OP_PEEK: begin
            if (s_op == bbrb_pkg::OP_READ) begin
              wr_left_d = '0;
              wr_acc_d  = 1'b0;
            end
            if ((len_c > MaxC) || (len_c > held_c)) begin
              res_o.status = 1'b1;
            end else begin
              if (s_op == bbrb_pkg::OP_READ) begin
                a_start_d  = AW'(cn_ast);
                a_size_d   = SW'(cn_asz);
                b_active_d = cn_bact;
                b_size_d   = SW'(cn_bsz);
                mv_src_d   = AW'(cn_tb);
                mv_len_d   = SW'(cn_asz);
              end
              if (len_c != '0) begin
                // bytes stream from the old region layout, relocation follows
                push_o     = 1'b0;
                state_d    = ST_READ;
                rd_len_d   = s_tdata_i[bbrb_pkg::LEN_W-1:0];
                rd_idx_d   = '0;
                rd_base_d  = a_start_q;
                rd_asz_d   = a_size_q;
                reloc_d    = (s_op == bbrb_pkg::OP_READ) && cn_reloc;
                held_res_d = (s_op == bbrb_pkg::OP_READ) ? bbrb_pkg::HELD_W'(cn_held) :
                                                          bbrb_pkg::HELD_W'(held_c);
              end
            end
          end
          bbrb_pkg::OP_REMOVE: begin
            wr_left_d = '0;
            wr_acc_d  = 1'b0;
            if (len_c > MaxC) begin
              res_o.status = 1'b1;
            end else begin
              a_start_d  = AW'(cn_ast);
              a_size_d   = SW'(cn_asz);
              b_active_d = cn_bact;
              b_size_d   = SW'(cn_bsz);
              mv_src_d   = AW'(cn_tb);
              mv_len_d   = SW'(cn_asz);
              mv_cnt_d   = '0;
              res_o.held_bytes = bbrb_pkg::HELD_W'(cn_held);
              if (cn_reloc) begin
                state_d = ST_RELOC;
              end
            end
          end
          default: begin
            res_o.status = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        if (room) begin
          ram_re_o  = 1'b1;
          rd_pend_d = 1'b1;
          rd_last_d = rd_is_last;
          rd_idx_d  = rd_idx_q + bbrb_pkg::LEN_W'(1);
          if (rd_is_last) begin
            state_d  = reloc_q ? ST_RELOC : ST_IDLE;
            mv_cnt_d = '0;
          end
        end
      end
      ST_RELOC: begin
        // copy b's remaining bytes down to offset zero, one per cycle
        ram_re_o    = 1'b1;
        ram_raddr_o = mv_src_q + mv_cnt_q;
        mv_vld_d    = 1'b1;
        if (mv_is_last) begin
          state_d = ST_IDLE;
          reloc_d = 1'b0;
        end else begin
          mv_cnt_d = mv_cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (mv_vld_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = mv_wa_q;
      ram_wdata_o = ram_rdata_i;
    end

    if (rd_pend_q) begin
      push_o           = 1'b1;
      res_o.status     = 1'b0;
      res_o.has_data   = 1'b1;
      res_o.out_byte   = ram_rdata_i;
      res_o.last       = rd_last_q;
      res_o.held_bytes = held_res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_start_q   <= '0;
      a_size_q    <= '0;
      b_active_q  <= 1'b0;
      b_size_q    <= '0;
      wr_left_q   <= '0;
      wr_into_b_q <= 1'b0;
      wr_acc_q    <= 1'b0;
      rd_idx_q    <= '0;
      rd_len_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      reloc_q     <= 1'b0;
      mv_cnt_q    <= '0;
      mv_len_q    <= '0;
      mv_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_start_q   <= a_start_d;
      a_size_q    <= a_size_d;
      b_active_q  <= b_active_d;
      b_size_q    <= b_size_d;
      wr_left_q   <= wr_left_d;
      wr_into_b_q <= wr_into_b_d;
      wr_acc_q    <= wr_acc_d;
      rd_idx_q    <= rd_idx_d;
      rd_len_q    <= rd_len_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      reloc_q     <= reloc_d;
      mv_cnt_q    <= mv_cnt_d;
      mv_len_q    <= mv_len_d;
      mv_vld_q    <= mv_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_base_q  <= rd_base_d;
    rd_asz_q   <= rd_asz_d;
    held_res_q <= held_res_d;
    mv_src_q   <= mv_src_d;
    mv_wa_q    <= mv_wa_d;
  end

endmodule

### rtl/bipartite_byte_ring_buffer.sv
// single-result items (writes, remove, refused or empty read and peek): one per cycle while the result queue has room
// read or peek of N bytes: bytes pass the read state, the store's registered read port and the result queue,
// one byte per cycle while the queue has room (single store read port); next item taken after the last byte lands
// a remove or read that empties region a and also takes bytes from the front of b, leaving b not empty,
// holds off new items while the rest of b is copied to offset zero through the same store ports
// reset clears region pointers, sizes and the pending write; the byte store is not cleared
module bipartite_byte_ring_buffer #(
  parameter int DEPTH        = bbrb_pkg::DEPTH_DEF,
  parameter int MAX_TRANSFER = bbrb_pkg::MAX_TRANSFER_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // length [6:0], data_byte [14:7], zero [15]
  input  logic [bbrb_pkg::S_DATA_W-1:0] s_axis_tdata,
  // operation [2:0]
  input  logic [bbrb_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status [0], out_byte [8:1], held_bytes [21:9], zero [23:22]
  output logic [bbrb_pkg::M_DATA_W-1:0] m_axis_tdata,
  // has_data [0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);

  bbrb_pkg::qstat_t            qstat;
  bbrb_pkg::res_t              res;
  logic                        push;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [bbrb_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  bbrb_ctrl #(
    .DEPTH        (DEPTH),
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .qstat_i     (qstat),
    .push_o      (push),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bbrb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bbrb_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res),
    .qstat_o    (qstat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

### rtl/bbrb_checker.sv
// port-level checks on the result stream of the bip buffer, bound to the top level
`include "bipartite_byte_ring_buffer_defines.svh"

module bbrb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bbrb_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  // a stalled transaction keeps its payload
  `BBRB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result changed while stalled")

  // a delivered byte is never part of a refused result
  `BBRB_ASSERT_IMPL(a_data_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[0], "byte delivered with refused status")

  // results without data stand alone
  `BBRB_ASSERT_IMPL(a_nodata_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "result without data not marked last")

  // byte field is zero when no byte is carried
  `BBRB_ASSERT_IMPL(a_nodata_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[8:1] == 8'd0, "stray byte on result without data")

endmodule

bind bipartite_byte_ring_buffer bbrb_checker u_bbrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
